[rtl/core/vfs_pkg.sv]
// shared word types and codes for the victim frame selector
package vfs_pkg;

    // default sizes
    localparam int FRAME_COUNT_DEF = 32;
    localparam int STAMP_BITS_DEF  = 32;

    // function codes of an input word
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    // replacement policy codes
    localparam logic MODE_RANDOM = 1'b0;
    localparam logic MODE_FIFO   = 1'b1;

    // input word
    typedef struct packed {
        logic        func;
        logic [4:0]  frame_index;
        logic        protect_flag;
        logic        mapped_flag;
        logic [31:0] stamp;
        logic [31:0] coin_bits;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [4:0] victim_frame;
        logic       was_mapped;
        logic       out_of_frames;
    } out_word_t;

endpackage

[rtl/core/vfs_cell.sv]
// one frame table entry plus one stage of the victim search chain
module vfs_cell #(
    parameter int FRAME_COUNT = vfs_pkg::FRAME_COUNT_DEF,
    parameter int STAMP_BITS  = vfs_pkg::STAMP_BITS_DEF,
    parameter int INDEX       = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [$clog2(FRAME_COUNT)-1:0] clr_idx,
    input  logic                           clr_en,
    input  logic                           wr_en,
    input  logic [4:0]                     wr_idx,
    input  logic                           wr_prot,
    input  logic                           wr_map,
    input  logic [STAMP_BITS-1:0]          wr_stamp,
    input  logic [4*$clog2(FRAME_COUNT)+STAMP_BITS+32+9-1:0] scan_in,
    output logic [4*$clog2(FRAME_COUNT)+STAMP_BITS+32+9-1:0] scan_out
);

    localparam int IW = $clog2(FRAME_COUNT);

    // search word handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic [31:0]           coins;
        logic                  free_found;
        logic [IW-1:0]         free_idx;
        logic                  rnd_found;
        logic [IW-1:0]         rnd_idx;
        logic                  rnd_mapped;
        logic                  seen;
        logic [IW-1:0]         last_idx;
        logic                  last_mapped;
        logic                  fifo_found;
        logic [IW-1:0]         fifo_idx;
        logic                  fifo_mapped;
        logic [STAMP_BITS-1:0] best;
    } scan_t;

    scan_t                 s_in;
    scan_t                 scan_next;
    scan_t                 scan_reg;
    logic                  prot_reg;
    logic                  prot_next;
    logic                  mapped_reg;
    logic                  mapped_next;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [STAMP_BITS-1:0] stamp_next;
    logic                  hit_wr;
    logic                  hit_clr;

    assign s_in     = scan_t'(scan_in);
    assign scan_out = scan_reg;

    // entry update: write from an input word, clear from a finished select
    assign hit_wr  = wr_en && (32'(wr_idx) == INDEX);
    assign hit_clr = clr_en && (clr_idx == IW'(INDEX));

    always_comb
    begin
        prot_next   = prot_reg;
        mapped_next = mapped_reg;
        stamp_next  = stamp_reg;
        if (hit_wr)
        begin
            prot_next   = wr_prot;
            mapped_next = wr_map;
            stamp_next  = wr_stamp;
        end
        else if (hit_clr)
        begin
            mapped_next = 1'b0;
        end
    end

    // search step for this entry
    always_comb
    begin
        scan_next       = s_in;
        scan_next.coins = s_in.coins >> 1;
        if (!prot_reg)
        begin
            if (!s_in.free_found && !mapped_reg)
            begin
                scan_next.free_found = 1'b1;
                scan_next.free_idx   = IW'(INDEX);
            end
            scan_next.seen        = 1'b1;
            scan_next.last_idx    = IW'(INDEX);
            scan_next.last_mapped = mapped_reg;
            if (!s_in.rnd_found && s_in.coins[0])
            begin
                scan_next.rnd_found  = 1'b1;
                scan_next.rnd_idx    = IW'(INDEX);
                scan_next.rnd_mapped = mapped_reg;
            end
            if (stamp_reg < s_in.best)
            begin
                scan_next.best        = stamp_reg;
                scan_next.fifo_found  = 1'b1;
                scan_next.fifo_idx    = IW'(INDEX);
                scan_next.fifo_mapped = mapped_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prot_reg   <= 1'b0;
            mapped_reg <= 1'b0;
            stamp_reg  <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            prot_reg   <= prot_next;
            mapped_reg <= mapped_next;
            stamp_reg  <= stamp_next;
            scan_reg   <= scan_next;
        end
    end

endmodule

[rtl/core/victim_frame_selector.sv]
// victim frame selector: frame table held in a chain of search cells
// a select word's search word passes the head register and the register of every cell; the result is registered
// a new word is accepted only once the search word has left the last cell, as busy stays high until then
// a write word gives no result; busy stays low
// reset clears the table to zero and sets the policy to fifo; results cannot be stalled
module victim_frame_selector #(
    parameter int FRAME_COUNT = vfs_pkg::FRAME_COUNT_DEF,
    parameter int STAMP_BITS  = vfs_pkg::STAMP_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  vfs_pkg::in_word_t  item,
    output logic               done,
    output vfs_pkg::out_word_t result,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);

    localparam int IW     = $clog2(FRAME_COUNT);
    localparam int SCAN_W = 4*IW+STAMP_BITS+32+9;

    // search word, same layout as in the cells
    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic [31:0]           coins;
        logic                  free_found;
        logic [IW-1:0]         free_idx;
        logic                  rnd_found;
        logic [IW-1:0]         rnd_idx;
        logic                  rnd_mapped;
        logic                  seen;
        logic [IW-1:0]         last_idx;
        logic                  last_mapped;
        logic                  fifo_found;
        logic [IW-1:0]         fifo_idx;
        logic                  fifo_mapped;
        logic [STAMP_BITS-1:0] best;
    } scan_t;

    logic               mode_reg;
    logic               mode_next;
    scan_t              head_reg;
    scan_t              head_next;
    logic [SCAN_W-1:0]  chain [FRAME_COUNT+1];
    logic [FRAME_COUNT:0] chain_valid;
    scan_t              tail;
    logic               accept;
    logic               wr_en;
    logic               sel_en;
    logic [STAMP_BITS-1:0] item_stamp;
    logic               found;
    logic [IW-1:0]      victim;
    logic               victim_mapped;
    vfs_pkg::out_word_t result_reg;
    vfs_pkg::out_word_t result_next;
    logic               done_reg;

    assign accept     = start && !busy;
    assign wr_en      = accept && (item.func == vfs_pkg::FUNC_WRITE);
    assign sel_en     = accept && (item.func == vfs_pkg::FUNC_SELECT);
    assign item_stamp = STAMP_BITS'(item.stamp);

    // policy register
    assign mode_next = cfg_we ? cfg_wdata : mode_reg;

    // search word seeded from a select word
    always_comb
    begin
        head_next       = '0;
        head_next.valid = sel_en;
        head_next.mode  = mode_reg;
        head_next.coins = item.coin_bits;
        head_next.best  = item_stamp;
    end

    assign chain[0] = head_reg;

    // cell row
    for (genvar g = 0; g < FRAME_COUNT; g++)
    begin : g_cell
        vfs_cell #(
            .FRAME_COUNT (FRAME_COUNT),
            .STAMP_BITS  (STAMP_BITS),
            .INDEX       (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clr_idx  (victim),
            .clr_en   (tail.valid && found),
            .wr_en    (wr_en),
            .wr_idx   (item.frame_index),
            .wr_prot  (item.protect_flag),
            .wr_map   (item.mapped_flag),
            .wr_stamp (item_stamp),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1])
        );
    end

    // busy while a search word is anywhere in the chain
    always_comb
    begin
        for (int k = 0; k <= FRAME_COUNT; k++)
        begin
            chain_valid[k] = chain[k][SCAN_W-1];
        end
    end
    assign busy = |chain_valid;

    // final pick from the search word leaving the last cell
    assign tail = scan_t'(chain[FRAME_COUNT]);

    always_comb
    begin
        found         = 1'b0;
        victim        = '0;
        victim_mapped = 1'b0;
        if (tail.free_found)
        begin
            found  = 1'b1;
            victim = tail.free_idx;
        end
        else if (tail.mode == vfs_pkg::MODE_RANDOM)
        begin
            if (tail.rnd_found)
            begin
                found         = 1'b1;
                victim        = tail.rnd_idx;
                victim_mapped = tail.rnd_mapped;
            end
            else if (tail.seen)
            begin
                found         = 1'b1;
                victim        = tail.last_idx;
                victim_mapped = tail.last_mapped;
            end
        end
        else if (tail.fifo_found)
        begin
            found         = 1'b1;
            victim        = tail.fifo_idx;
            victim_mapped = tail.fifo_mapped;
        end
        result_next.victim_frame  = 5'(victim);
        result_next.was_mapped    = victim_mapped;
        result_next.out_of_frames = !found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= vfs_pkg::MODE_FIFO;
            head_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            head_reg <= head_next;
            done_reg <= tail.valid;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/core/vfs_checker.sv]
// port level checks for the victim frame selector, bound to the top level
module vfs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input vfs_pkg::in_word_t  item,
    input logic               done,
    input vfs_pkg::out_word_t result,
    input logic               cfg_we,
    input logic               cfg_wdata
);

    // an accepted select word starts a search
    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.func == vfs_pkg::FUNC_SELECT) |=> busy)
        else $error("select word did not raise busy");

    // an accepted write word finishes at once and gives no result
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.func == vfs_pkg::FUNC_WRITE) |=> (!busy && !done))
        else $error("write word caused busy or a result");

    // a result is shown only once the chain has emptied
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !$past(done)))
        else $error("result strobe while busy or repeated");

    // out of frames reports frame zero, not mapped
    a_oof_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.out_of_frames) |-> (result.victim_frame == 5'd0 && !result.was_mapped))
        else $error("out of frames result carries a frame");

endmodule

bind victim_frame_selector vfs_checker u_vfs_checker (.*);

[tb/sv/vfs_result_checker.sv]
// result checker for the victim frame selector: predicts each select and compares results
`timescale 1ns / 100ps

module vfs_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  vfs_pkg::in_word_t  item,
    input  logic               done,
    input  vfs_pkg::out_word_t result,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output int                 fail_count,
    output int                 pending
);

    localparam int FRAMES = vfs_pkg::FRAME_COUNT_DEF;

    // shadow frame table and policy
    logic        protect_tab [FRAMES];
    logic        mapped_tab  [FRAMES];
    logic [31:0] stamp_tab   [FRAMES];
    logic        policy;

    vfs_pkg::out_word_t victim_q [$];
    vfs_pkg::out_word_t want;
    int                 errors;

    assign fail_count = errors;

    // one line per mismatch, counting every one
    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
        errors++;
    endtask

    // pick the victim frame for a select word and clear its mapped bit
    function automatic vfs_pkg::out_word_t select_victim(input vfs_pkg::in_word_t w);
        vfs_pkg::out_word_t r;
        logic        found;
        logic        seen;
        logic [31:0] oldest;
        int          victim;
        int          last_open;
        found     = 1'b0;
        seen      = 1'b0;
        victim    = 0;
        last_open = 0;
        oldest    = w.stamp;
        r         = '0;
        // a frame that is neither protected nor mapped wins outright
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!found && !protect_tab[i] && !mapped_tab[i])
            begin
                found  = 1'b1;
                victim = i;
            end
        end
        if (!found && policy == vfs_pkg::MODE_RANDOM)
        begin
            // first open frame with its coin set, else the last open frame
            for (int i = 0; i < FRAMES; i++)
            begin
                if (!found && !protect_tab[i])
                begin
                    seen      = 1'b1;
                    last_open = i;
                    if (w.coin_bits[i])
                    begin
                        found  = 1'b1;
                        victim = i;
                    end
                end
            end
            if (!found && seen)
            begin
                found  = 1'b1;
                victim = last_open;
            end
        end
        else if (!found)
        begin
            // oldest stamp strictly below the current one, lowest index on ties
            for (int i = 0; i < FRAMES; i++)
            begin
                if (!protect_tab[i] && stamp_tab[i] < oldest)
                begin
                    oldest = stamp_tab[i];
                    victim = i;
                    found  = 1'b1;
                end
            end
        end
        if (!found)
        begin
            r.out_of_frames = 1'b1;
        end
        else
        begin
            r.victim_frame     = 5'(victim);
            r.was_mapped       = mapped_tab[victim];
            mapped_tab[victim] = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                protect_tab[i] = 1'b0;
                mapped_tab[i]  = 1'b0;
                stamp_tab[i]   = '0;
            end
            policy = vfs_pkg::MODE_FIFO;
            victim_q.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            // finished word against the oldest expectation
            if (done)
            begin
                if (victim_q.size() == 0)
                begin
                    report_mismatch("result word with nothing expected", 1, 0);
                end
                else
                begin
                    want = victim_q.pop_front();
                    if (result.victim_frame !== want.victim_frame)
                    begin
                        report_mismatch("victim_frame", result.victim_frame, want.victim_frame);
                    end
                    if (result.was_mapped !== want.was_mapped)
                    begin
                        report_mismatch("was_mapped", result.was_mapped, want.was_mapped);
                    end
                    if (result.out_of_frames !== want.out_of_frames)
                    begin
                        report_mismatch("out_of_frames", result.out_of_frames,
                                        want.out_of_frames);
                    end
                end
            end
            // accepted word updates the shadow table or queues a prediction
            if (start && !busy)
            begin
                if (item.func == vfs_pkg::FUNC_SELECT)
                begin
                    victim_q.push_back(select_victim(item));
                end
                else
                begin
                    protect_tab[item.frame_index] = item.protect_flag;
                    mapped_tab[item.frame_index]  = item.mapped_flag;
                    stamp_tab[item.frame_index]   = item.stamp;
                end
            end
            // policy register write
            if (cfg_we)
            begin
                policy = cfg_wdata;
            end
            pending <= victim_q.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// top of the victim frame selector testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;

    localparam int FRAMES        = vfs_pkg::FRAME_COUNT_DEF;
    localparam int SETTLE_CYCLES = vfs_pkg::FRAME_COUNT_DEF + 8;
    localparam int IDLE_LIMIT    = 4000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    vfs_pkg::in_word_t  item;
    logic               done;
    vfs_pkg::out_word_t result;
    logic               cfg_we;
    logic               cfg_wdata;
    int                 fail_count;
    int                 pending;

    int        sent_words  = 0;
    int        idle_odds   = 0;
    int        idle_cycles = 0;

    victim_frame_selector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    vfs_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic vfs_pkg::in_word_t make_word(input logic f, input logic [4:0] idx,
                                                    input logic prot, input logic mapped,
                                                    input logic [31:0] stamp,
                                                    input logic [31:0] coins);
        vfs_pkg::in_word_t w;
        w.func         = f;
        w.frame_index  = idx;
        w.protect_flag = prot;
        w.mapped_flag  = mapped;
        w.stamp        = stamp;
        w.coin_bits    = coins;
        return w;
    endfunction

    // stamps clustered near a base so that ties and near misses are common
    function automatic logic [31:0] stamp_near(input logic [31:0] base, input int spread);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return base + 32'($urandom_range(0, spread));
        endcase
    endfunction

    function automatic logic [31:0] coin_pattern();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // present one word and hold it until accepted; start stays high afterwards
    task automatic send_word(input vfs_pkg::in_word_t w);
        if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
        sent_words++;
    endtask

    // let every expected result arrive and the block settle
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_policy(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // fill the frame table, then fault on it a few times; or, one kind in ten, send random words
    task automatic run_fault_burst();
        int                 kind;
        int                 offset;
        int                 n_sel;
        logic               reactive;
        logic [31:0]        base;
        logic [31:0]        sel_stamp;
        vfs_pkg::out_word_t got;
        vfs_pkg::in_word_t  w;
        kind     = $urandom_range(0, 9);
        base     = $urandom;
        reactive = 1'($urandom_range(0, 1));
        if (kind == 9)
        begin
            // noise: fully random words
            repeat ($urandom_range(1, 8))
            begin
                send_word(make_word(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    $urandom, $urandom));
            end
        end
        else
        begin
            // table sweep; every frame protected in the first kind
            offset = $urandom_range(0, FRAMES - 1);
            for (int k = 0; k < FRAMES; k++)
            begin
                w = make_word(vfs_pkg::FUNC_WRITE, 5'(k + offset), 1'b1,
                              1'($urandom_range(0, 1)), stamp_near(base, 63), $urandom);
                if (kind != 0)
                begin
                    w.protect_flag = ($urandom_range(0, 3) == 0);
                    w.mapped_flag  = ($urandom_range(0, 15) != 0);
                end
                send_word(w);
            end
            n_sel = reactive ? $urandom_range(2, 10) : $urandom_range(1, 6);
            repeat (n_sel)
            begin
                sel_stamp = stamp_near(base, 96);
                send_word(make_word(vfs_pkg::FUNC_SELECT, 5'($urandom_range(0, 31)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    sel_stamp, coin_pattern()));
                if (reactive)
                begin
                    // map the victim again, as the fault handler would
                    start <= 1'b0;
                    do @(posedge clk); while (!(done === 1'b1 && pending == 1));
                    got = result;
                    if (!got.out_of_frames)
                    begin
                        send_word(make_word(vfs_pkg::FUNC_WRITE, got.victim_frame, 1'b0, 1'b1,
                                            sel_stamp, $urandom));
                    end
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    send_word(make_word(vfs_pkg::FUNC_WRITE, 5'($urandom_range(0, 31)),
                                        1'b0, 1'b1, stamp_near(base, 63), $urandom));
                end
            end
        end
    endtask

    task automatic run_phase(input logic mode, input int odds, input int words);
        int goal;
        drain_pipeline();
        write_policy(mode);
        idle_odds = odds;
        goal      = sent_words + words;
        while (sent_words < goal) run_fault_burst();
    endtask

    // stimulus
    initial
    begin
        start     <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        rst_n     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n     <= 1'b1;
        @(posedge clk);

        // directed, fifo policy from reset
        idle_odds = 3;
        send_word(make_word(vfs_pkg::FUNC_SELECT, 5'd0, 1'b0, 1'b0, 32'h0, 32'h0));
        send_word(make_word(vfs_pkg::FUNC_WRITE, 5'd0, 1'b0, 1'b1, '1, '1));
        send_word(make_word(vfs_pkg::FUNC_WRITE, 5'd31, 1'b1, 1'b1, 32'h0, 32'h0));
        send_word(make_word(vfs_pkg::FUNC_SELECT, 5'd31, 1'b1, 1'b1, '1, '1));
        send_word(make_word(vfs_pkg::FUNC_WRITE, 5'd1, 1'b0, 1'b0, 32'h8000_0000,
                            32'h5555_5555));
        send_word(make_word(vfs_pkg::FUNC_SELECT, 5'd0, 1'b0, 1'b0, 32'h1, 32'hAAAA_AAAA));

        // directed, random policy
        drain_pipeline();
        write_policy(vfs_pkg::MODE_RANDOM);
        send_word(make_word(vfs_pkg::FUNC_SELECT, 5'd0, 1'b0, 1'b0, 32'h0, 32'h0));
        send_word(make_word(vfs_pkg::FUNC_SELECT, 5'd0, 1'b0, 1'b0, '1, '1));
        send_word(make_word(vfs_pkg::FUNC_WRITE, 5'd2, 1'b1, 1'b1, 32'h5555_5555,
                            32'hAAAA_AAAA));
        send_word(make_word(vfs_pkg::FUNC_SELECT, 5'd2, 1'b1, 1'b1, 32'hAAAA_AAAA,
                            32'h5555_5555));

        // random phases, alternating policy; the third and the last run without gaps
        run_phase(vfs_pkg::MODE_FIFO, 4, 280);
        run_phase(vfs_pkg::MODE_RANDOM, 2, 280);
        run_phase(vfs_pkg::MODE_FIFO, 0, 280);
        run_phase(vfs_pkg::MODE_RANDOM, 3, 280);
        run_phase(vfs_pkg::MODE_FIFO, 0, 300);

        drain_pipeline();
        if (fail_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/vfs_pkg.sv
rtl/core/vfs_cell.sv
rtl/core/victim_frame_selector.sv
rtl/core/vfs_checker.sv
tb/sv/vfs_result_checker.sv
tb/sv/testbench.sv
